// ----- rtl/evcm_pkg.sv -----
package evcm_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;
    localparam int XW           = 34;
    localparam int ZW           = 27;
    localparam int DIV_BITS     = 14;
    localparam int DIV_STEP_W   = 4;
    localparam int NUM_W        = 47;

    localparam logic signed [XW-1:0] CORDIC_K = XW'(652032874);
    localparam logic signed [ZW-1:0] DEG180   = ZW'(180 * 65536);

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FRONT = 2'd2;

    typedef struct packed {
        logic signed [31:0]          pos_x;
        logic signed [31:0]          pos_y;
        logic signed [31:0]          pos_z;
        logic signed [13:0]          pitch;
        logic                        deg;
        logic                        neg_p;
        logic                        neg_y;
        logic                        sg;
        logic signed [XW-1:0]        xp;
        logic signed [XW-1:0]        yp;
        logic signed [XW-1:0]        xy;
        logic signed [XW-1:0]        yy;
        logic signed [XW-1:0]        vx;
        logic signed [XW-1:0]        vy;
        logic signed [ZW-1:0]        zp;
        logic signed [ZW-1:0]        zy;
        logic signed [ZW-1:0]        vz;
        logic signed [31:0]          cp;
        logic signed [31:0]          sp;
        logic signed [31:0]          cy;
        logic signed [31:0]          sy;
        logic [31:0]                 den;
        logic [13:0]                 pabs;
        logic signed [63:0]          pr_cysp;
        logic signed [63:0]          pr_sysp;
        logic signed [63:0]          pr_cycp;
        logic signed [63:0]          pr_sycp;
        logic [NUM_W-1:0]            rem_p;
        logic [NUM_W-1:0]            rem_r;
        logic [DIV_BITS-1:0]         q_p;
        logic [DIV_BITS-1:0]         q_r;
        logic signed [14:0]          ayaw;
        logic [2:0][2:0][15:0]       m;
        logic [2:0][2:0][47:0]       tp;
        logic [2:0][31:0]            trans;
        logic signed [13:0]          apitch;
        logic signed [13:0]          aroll;
    } item_t;

    // atan(2^-i) in degrees Q.16
    function automatic logic signed [ZW-1:0] atan_deg(input logic [STEP_W-1:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:    r = ZW'(2949120);
            5'd1:    r = ZW'(1740967);
            5'd2:    r = ZW'(919879);
            5'd3:    r = ZW'(466945);
            5'd4:    r = ZW'(234379);
            5'd5:    r = ZW'(117304);
            5'd6:    r = ZW'(58666);
            5'd7:    r = ZW'(29335);
            5'd8:    r = ZW'(14668);
            5'd9:    r = ZW'(7334);
            5'd10:   r = ZW'(3667);
            5'd11:   r = ZW'(1833);
            5'd12:   r = ZW'(917);
            5'd13:   r = ZW'(458);
            5'd14:   r = ZW'(229);
            5'd15:   r = ZW'(115);
            5'd16:   r = ZW'(57);
            5'd17:   r = ZW'(29);
            5'd18:   r = ZW'(14);
            5'd19:   r = ZW'(7);
            5'd20:   r = ZW'(4);
            5'd21:   r = ZW'(2);
            5'd22:   r = ZW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/euler_camera_view_matrix.sv -----
// Camera view matrix from position and pitch/yaw angles.
// Input stream s_axis: one word per camera pose (position Q16.16, pitch and
// yaw in degrees x64). Output stream m_axis: three words per pose, the right,
// up and negated-front rows of the view matrix with their translation, plus
// the adjusted pitch/yaw/roll; tlast marks the third row.
// Datapath is a row of cells: CORDIC_STEPS rotation cells (sin/cos of both
// angles), CORDIC_STEPS vectoring cells (atan2 for yaw), DIV_BITS restoring
// divider cells (pitch/roll shares), framed by a few single-stage steps.
// Throughput is bound by the output port emitting three rows per pose; a new
// pose is accepted while the rows of the previous one are still being sent.
// When m_axis_tready is low, empty slots keep moving until a finished pose
// waits behind the serializer; then the whole cell row freezes and
// s_axis_tready drops. Reset clears all valid flags and the row
// serializer; no clearing pass is needed.
module euler_camera_view_matrix
    import evcm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x[31:0] pos_y[63:32] pos_z[95:64] pitch_deg[109:96] yaw_deg[125:110]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // col_a[15:0] col_b[31:16] col_c[47:32] translation[79:48]
    // adj_pitch[93:80] adj_yaw[108:94] adj_roll[122:109]
    output logic [127:0] m_axis_tdata,
    // row_index[1:0] degenerate[2]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    logic  adv;
    logic  take;

    // ---------------- stage 0: angle reduction -----------------------------
    logic  v0_reg;
    item_t s0_reg, s0_next;

    function automatic void fold(input logic signed [16:0] a_in,
                                 output logic signed [ZW-1:0] z, output logic neg);
        logic signed [16:0] a;
        a   = a_in;
        neg = 1'b0;
        if (a >= 17'sd23040)
            a = a - 17'sd23040;
        else if (a <= -17'sd23040)
            a = a + 17'sd23040;
        if (a >= 17'sd11520)
            a = a - 17'sd23040;
        if (a < -17'sd11520)
            a = a + 17'sd23040;
        if (a > 17'sd5760)
        begin
            a   = a - 17'sd11520;
            neg = 1'b1;
        end
        else if (a < -17'sd5760)
        begin
            a   = a + 17'sd11520;
            neg = 1'b1;
        end
        z = ZW'(a) <<< 10;
    endfunction

    always_comb
    begin
        logic signed [ZW-1:0] zp;
        logic signed [ZW-1:0] zy;
        logic                 np;
        logic                 ny;
        s0_next        = '0;
        s0_next.pos_x  = s_axis_tdata[31:0];
        s0_next.pos_y  = s_axis_tdata[63:32];
        s0_next.pos_z  = s_axis_tdata[95:64];
        s0_next.pitch  = s_axis_tdata[109:96];
        fold(17'(s0_next.pitch), zp, np);
        fold(17'($signed(s_axis_tdata[125:110])), zy, ny);
        s0_next.deg    = (s0_next.pitch == 14'sd5760) || (s0_next.pitch == -14'sd5760);
        s0_next.zp     = zp;
        s0_next.zy     = zy;
        s0_next.neg_p  = np;
        s0_next.neg_y  = ny;
        s0_next.xp     = CORDIC_K;
        s0_next.xy     = CORDIC_K;
    end

    // ---------------- rotation cells ----------------------------------------
    item_t rot_item [0:CORDIC_STEPS];
    logic  rot_vld  [0:CORDIC_STEPS];

    assign rot_item[0] = s0_reg;
    assign rot_vld[0]  = v0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        evcm_rot_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .step     (STEP_W'(i)),
            .in_vld   (rot_vld[i]),
            .in_item  (rot_item[i]),
            .out_vld  (rot_vld[i+1]),
            .out_item (rot_item[i+1])
        );
    end

    // ---------------- stage F: sign fix, atan2 preset -----------------------
    logic  vf_reg;
    item_t f_reg, f_next;

    always_comb
    begin
        item_t r;
        logic signed [XW-1:0] c_p;
        logic signed [XW-1:0] s_p;
        logic signed [XW-1:0] c_y;
        logic signed [XW-1:0] s_y;
        logic signed [XW-1:0] x0;
        logic signed [XW-1:0] y0;
        r   = rot_item[CORDIC_STEPS];
        c_p = r.neg_p ? -r.xp : r.xp;
        s_p = r.neg_p ? -r.yp : r.yp;
        c_y = r.neg_y ? -r.xy : r.xy;
        s_y = r.neg_y ? -r.yy : r.yy;
        f_next    = r;
        f_next.cp = 32'(c_p);
        f_next.sp = 32'(s_p);
        f_next.cy = 32'(c_y);
        f_next.sy = 32'(s_y);
        f_next.sg = c_p < 0;
        x0 = f_next.sg ? -c_y : c_y;
        y0 = f_next.sg ? -s_y : s_y;
        if (x0 < 0)
        begin
            f_next.vz = (y0 >= 0) ? DEG180 : -DEG180;
            f_next.vx = -x0;
            f_next.vy = -y0;
        end
        else
        begin
            f_next.vz = '0;
            f_next.vx = x0;
            f_next.vy = y0;
        end
        f_next.den  = 32'(c_y < 0 ? -c_y : c_y) + 32'(s_y < 0 ? -s_y : s_y);
        f_next.pabs = 14'(r.pitch < 0 ? -r.pitch : r.pitch);
    end

    // ---------------- vectoring cells ---------------------------------------
    item_t vec_item [0:CORDIC_STEPS];
    logic  vec_vld  [0:CORDIC_STEPS];

    assign vec_item[0] = f_reg;
    assign vec_vld[0]  = vf_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        evcm_vec_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .step     (STEP_W'(i)),
            .in_vld   (vec_vld[i]),
            .in_item  (vec_item[i]),
            .out_vld  (vec_vld[i+1]),
            .out_item (vec_item[i+1])
        );
    end

    // ---------------- stage M: products, yaw rounding -----------------------
    logic  vm_reg;
    item_t m_reg, m_next;

    always_comb
    begin
        item_t r;
        logic [31:0]          acy;
        logic [31:0]          asy;
        logic signed [ZW-11:0] yr;
        r      = vec_item[CORDIC_STEPS];
        m_next = r;
        acy    = 32'(r.cy < 0 ? -r.cy : r.cy);
        asy    = 32'(r.sy < 0 ? -r.sy : r.sy);
        m_next.pr_cysp = 64'(r.cy) * 64'(r.sp);
        m_next.pr_sysp = 64'(r.sy) * 64'(r.sp);
        m_next.pr_cycp = 64'(r.cy) * 64'(r.cp);
        m_next.pr_sycp = 64'(r.sy) * 64'(r.cp);
        m_next.rem_p   = ((NUM_W'(r.pabs) * NUM_W'(acy)) << 1) + NUM_W'(r.den);
        m_next.rem_r   = ((NUM_W'(r.pabs) * NUM_W'(asy)) << 1) + NUM_W'(r.den);
        m_next.q_p     = '0;
        m_next.q_r     = '0;
        yr = (ZW-10)'((r.vz + ZW'(512)) >>> 10);
        if (yr > (ZW-10)'(11520))
            yr = yr - (ZW-10)'(23040);
        if (yr < -(ZW-10)'(11520))
            yr = yr + (ZW-10)'(23040);
        m_next.ayaw = 15'(yr);
    end

    // ---------------- stage R: row entries ----------------------------------
    logic  vr_reg;
    item_t r_reg, r_next;

    function automatic logic [15:0] to_q14(input logic signed [35:0] v);
        logic signed [19:0] t;
        t = 20'((v + 36'sd32768) >>> 16);
        if (t > 20'sd16384)
            t = 20'sd16384;
        if (t < -20'sd16384)
            t = -20'sd16384;
        return 16'(t);
    endfunction

    function automatic logic signed [35:0] mulq(input logic signed [63:0] pr);
        logic signed [63:0] s;
        s = pr + 64'sd536870912;
        return 36'($signed(s[63:30]));
    endfunction

    always_comb
    begin
        item_t r;
        logic signed [35:0] q_cysp;
        logic signed [35:0] q_sysp;
        r      = m_reg;
        r_next = r;
        q_cysp = mulq(r.pr_cysp);
        q_sysp = mulq(r.pr_sysp);
        r_next.m[0][0] = to_q14(r.sg ? 36'(r.sy) : -36'(r.sy));
        r_next.m[0][1] = '0;
        r_next.m[0][2] = to_q14(r.sg ? -36'(r.cy) : 36'(r.cy));
        r_next.m[1][0] = to_q14(r.sg ? q_cysp : -q_cysp);
        r_next.m[1][1] = to_q14(r.sg ? -36'(r.cp) : 36'(r.cp));
        r_next.m[1][2] = to_q14(r.sg ? q_sysp : -q_sysp);
        r_next.m[2][0] = to_q14(-mulq(r.pr_cycp));
        r_next.m[2][1] = to_q14(-36'(r.sp));
        r_next.m[2][2] = to_q14(-mulq(r.pr_sycp));
    end

    // ---------------- divider cells -----------------------------------------
    item_t div_item [0:DIV_BITS];
    logic  div_vld  [0:DIV_BITS];

    assign div_item[0] = r_reg;
    assign div_vld[0]  = vr_reg;

    for (genvar i = 0; i < DIV_BITS; i++)
    begin : g_div
        evcm_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .step     (DIV_STEP_W'(DIV_BITS - 1 - i)),
            .in_vld   (div_vld[i]),
            .in_item  (div_item[i]),
            .out_vld  (div_vld[i+1]),
            .out_item (div_item[i+1])
        );
    end

    // ---------------- stage P: translation products -------------------------
    logic  vp_reg;
    item_t p_reg, p_next;

    always_comb
    begin
        item_t r;
        r      = div_item[DIV_BITS];
        p_next = r;
        for (int k = 0; k < 3; k++)
        begin
            p_next.tp[k][0] = 48'($signed(r.m[k][0])) * 48'(r.pos_x);
            p_next.tp[k][1] = 48'($signed(r.m[k][1])) * 48'(r.pos_y);
            p_next.tp[k][2] = 48'($signed(r.m[k][2])) * 48'(r.pos_z);
        end
        p_next.apitch = r.pitch < 0 ? -14'(r.q_p) : 14'(r.q_p);
        p_next.aroll  = r.pitch < 0 ? -14'(r.q_r) : 14'(r.q_r);
    end

    // ---------------- stage T: sum, round, saturate -------------------------
    logic  vt_reg;
    item_t t_reg, t_next;

    always_comb
    begin
        logic signed [49:0] sum;
        logic signed [49:0] t;
        t_next = p_reg;
        for (int k = 0; k < 3; k++)
        begin
            sum = 50'($signed(p_reg.tp[k][0])) + 50'($signed(p_reg.tp[k][1]))
                + 50'($signed(p_reg.tp[k][2]));
            t   = -((sum + 50'sd8192) >>> 14);
            if (t > 50'sd2147483647)
                t = 50'sd2147483647;
            if (t < -50'sd2147483648)
                t = -50'sd2147483648;
            t_next.trans[k] = 32'(t);
        end
    end

    // ---------------- pipeline registers ------------------------------------
    assign adv           = !vt_reg || take;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            vf_reg <= 1'b0;
            vm_reg <= 1'b0;
            vr_reg <= 1'b0;
            vp_reg <= 1'b0;
            vt_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= s_axis_tvalid;
            vf_reg <= rot_vld[CORDIC_STEPS];
            vm_reg <= vec_vld[CORDIC_STEPS];
            vr_reg <= vm_reg;
            vp_reg <= div_vld[DIV_BITS];
            vt_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= s0_next;
            f_reg  <= f_next;
            m_reg  <= m_next;
            r_reg  <= r_next;
            p_reg  <= p_next;
            t_reg  <= t_next;
        end
    end

    // ---------------- row serializer ----------------------------------------
    // Holds one finished pose and sends its three rows; a new pose is loaded
    // while the serializer is idle or on the cycle the last row leaves.
    logic       busy_reg;
    logic [1:0] row_reg;
    item_t      hold_reg;

    assign take = vt_reg && (!busy_reg || (row_reg == ROW_FRONT && m_axis_tready));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= ROW_RIGHT;
        end
        else if (take)
        begin
            busy_reg <= 1'b1;
            row_reg  <= ROW_RIGHT;
        end
        else if (busy_reg && m_axis_tready)
        begin
            if (row_reg == ROW_FRONT)
                busy_reg <= 1'b0;
            else
                row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            hold_reg <= t_reg;
    end

    always_comb
    begin
        m_axis_tdata = '0;
        if (!hold_reg.deg)
        begin
            m_axis_tdata[15:0]    = hold_reg.m[row_reg][0];
            m_axis_tdata[31:16]   = hold_reg.m[row_reg][1];
            m_axis_tdata[47:32]   = hold_reg.m[row_reg][2];
            m_axis_tdata[79:48]   = hold_reg.trans[row_reg];
            m_axis_tdata[93:80]   = hold_reg.apitch;
            m_axis_tdata[108:94]  = hold_reg.ayaw;
            m_axis_tdata[122:109] = hold_reg.aroll;
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tuser  = {hold_reg.deg, row_reg};
    assign m_axis_tlast  = (row_reg == ROW_FRONT);

    // ---------------- checks ------------------------------------------------
    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> vt_reg)
        else $error("pose loaded without a finished item");

    a_last_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast && !take) |=> !m_axis_tvalid)
        else $error("output still valid after last row");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata == '0))
        else $error("degenerate row carries data");

    a_right_col_b: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && row_reg == ROW_RIGHT) |-> (m_axis_tdata[31:16] == 16'd0))
        else $error("right row has nonzero y element");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (vt_reg && busy_reg && !m_axis_tready) |=> (vt_reg && $stable(row_reg)))
        else $error("pipeline moved while output stalled");

endmodule

// ----- rtl/evcm_rot_cell.sv -----
// One rotation-mode step for both the pitch and the yaw sin/cos.
module evcm_rot_cell
    import evcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [STEP_W-1:0] step,
    input  logic              in_vld,
    input  item_t             in_item,
    output logic              out_vld,
    output item_t             out_item
);

    logic  vld_reg;
    item_t item_reg;
    item_t item_next;
    logic signed [ZW-1:0] ang;

    always_comb
    begin
        item_next = in_item;
        ang       = atan_deg(step);
        if (in_item.zp >= 0)
        begin
            item_next.xp = in_item.xp - (in_item.yp >>> step);
            item_next.yp = in_item.yp + (in_item.xp >>> step);
            item_next.zp = in_item.zp - ang;
        end
        else
        begin
            item_next.xp = in_item.xp + (in_item.yp >>> step);
            item_next.yp = in_item.yp - (in_item.xp >>> step);
            item_next.zp = in_item.zp + ang;
        end
        if (in_item.zy >= 0)
        begin
            item_next.xy = in_item.xy - (in_item.yy >>> step);
            item_next.yy = in_item.yy + (in_item.xy >>> step);
            item_next.zy = in_item.zy - ang;
        end
        else
        begin
            item_next.xy = in_item.xy + (in_item.yy >>> step);
            item_next.yy = in_item.yy - (in_item.xy >>> step);
            item_next.zy = in_item.zy + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

// ----- rtl/evcm_vec_cell.sv -----
// One vectoring-mode step: drives vy toward zero, accumulates angle in vz.
module evcm_vec_cell
    import evcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [STEP_W-1:0] step,
    input  logic              in_vld,
    input  item_t             in_item,
    output logic              out_vld,
    output item_t             out_item
);

    logic  vld_reg;
    item_t item_reg;
    item_t item_next;

    always_comb
    begin
        item_next = in_item;
        if (in_item.vy >= 0)
        begin
            item_next.vx = in_item.vx + (in_item.vy >>> step);
            item_next.vy = in_item.vy - (in_item.vx >>> step);
            item_next.vz = in_item.vz + atan_deg(step);
        end
        else
        begin
            item_next.vx = in_item.vx - (in_item.vy >>> step);
            item_next.vy = in_item.vy + (in_item.vx >>> step);
            item_next.vz = in_item.vz - atan_deg(step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

// ----- rtl/evcm_div_cell.sv -----
// One restoring-division bit for the pitch and roll shares (divisor 2*den).
module evcm_div_cell
    import evcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [DIV_STEP_W-1:0] step,
    input  logic                  in_vld,
    input  item_t                 in_item,
    output logic                  out_vld,
    output item_t                 out_item
);

    logic             vld_reg;
    item_t            item_reg;
    item_t            item_next;
    logic [NUM_W-1:0] dsh;

    always_comb
    begin
        item_next = in_item;
        dsh       = NUM_W'({in_item.den, 1'b0}) << step;
        if (in_item.rem_p >= dsh)
        begin
            item_next.rem_p     = in_item.rem_p - dsh;
            item_next.q_p[step] = 1'b1;
        end
        if (in_item.rem_r >= dsh)
        begin
            item_next.rem_r     = in_item.rem_r - dsh;
            item_next.q_r[step] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    import evcm_pkg::*;

    localparam int PIPE_LAT   = 2 * CORDIC_STEPS + 21;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 80;
    localparam int N_FILL     = 70;
    localparam int MAX_STEPS  = 24;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [15:0] col_a;
        logic signed [15:0] col_b;
        logic signed [15:0] col_c;
        logic signed [31:0] trans;
        logic signed [13:0] apitch;
        logic signed [14:0] ayaw;
        logic signed [13:0] aroll;
        logic               degen;
        logic               last;
    } row_word_t;

    // atan(2^-i) in degrees Q.16, own copy
    localparam longint ATAN_TBL [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    function automatic longint fshr(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // rotation-mode CORDIC: angle in deg*64 -> cos, sin in Q30
    function automatic void sin_cos(input longint a64, output longint c, output longint s);
        longint a, x, y, z, xn, yn;
        bit flip;
        int nsteps;
        nsteps = CORDIC_STEPS < MAX_STEPS ? CORDIC_STEPS : MAX_STEPS;
        a = a64 % 23040;
        flip = 0;
        if (a >= 11520) a -= 23040;
        if (a < -11520) a += 23040;
        if (a > 5760) begin a -= 11520; flip = 1; end
        else if (a < -5760) begin a += 11520; flip = 1; end
        x = 652032874;
        y = 0;
        z = a * 1024;
        for (int i = 0; i < nsteps; i++)
        begin
            if (z >= 0)
            begin
                xn = x - fshr(y, i); yn = y + fshr(x, i); z -= ATAN_TBL[i];
            end
            else
            begin
                xn = x + fshr(y, i); yn = y - fshr(x, i); z += ATAN_TBL[i];
            end
            x = xn; y = yn;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // vectoring-mode CORDIC: atan2(y, x) in degrees Q.16
    function automatic longint heading_deg(longint x, longint y);
        longint z, xn, yn;
        int nsteps;
        nsteps = CORDIC_STEPS < MAX_STEPS ? CORDIC_STEPS : MAX_STEPS;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? (180 <<< 16) : -(180 <<< 16);
            x = -x; y = -y;
        end
        for (int i = 0; i < nsteps; i++)
        begin
            if (y >= 0)
            begin
                xn = x + fshr(y, i); yn = y - fshr(x, i); z += ATAN_TBL[i];
            end
            else
            begin
                xn = x - fshr(y, i); yn = y + fshr(x, i); z -= ATAN_TBL[i];
            end
            x = xn; y = yn;
        end
        return z;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return fshr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic longint q30_to_q14(longint v);
        longint r;
        r = fshr(v + (64'sd1 <<< 15), 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    function automatic longint angle_share(longint p, longint num, longint den);
        longint m;
        m = (mag(p) * num * 2 + den) / (den * 2);
        return p < 0 ? -m : m;
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard: computes the three view-matrix rows of a pose
    // ---------------------------------------------------------------
    class view_scoreboard;
        row_word_t pending_rows[$];
        int        n_mismatch;

        function void note_pose(logic [127:0] d);
            longint px[3], p, yw, cp, sp, cy, sy, sg, acp, den, ap, ar, ay, t;
            longint m[3][3];
            bit vert;
            row_word_t w;
            px[0] = longint'($signed(d[31:0]));
            px[1] = longint'($signed(d[63:32]));
            px[2] = longint'($signed(d[95:64]));
            p     = longint'($signed(d[109:96]));
            yw    = longint'($signed(d[125:110]));
            vert  = (p == 5760 || p == -5760);
            sin_cos(p, cp, sp);
            sin_cos(yw, cy, sy);
            sg  = cp < 0 ? -1 : 1;
            acp = mag(cp);
            m[0][0] = q30_to_q14(-sg * sy);
            m[0][1] = 0;
            m[0][2] = q30_to_q14(sg * cy);
            m[1][0] = q30_to_q14(-sg * mul_q30(cy, sp));
            m[1][1] = q30_to_q14(acp);
            m[1][2] = q30_to_q14(-sg * mul_q30(sy, sp));
            m[2][0] = q30_to_q14(-mul_q30(cy, cp));
            m[2][1] = q30_to_q14(-sp);
            m[2][2] = q30_to_q14(-mul_q30(sy, cp));
            den = mag(cy) + mag(sy);
            ap  = angle_share(p, mag(cy), den);
            ar  = angle_share(p, mag(sy), den);
            ay  = fshr(heading_deg(sg * cy, sg * sy) + 512, 10);
            if (ay > 11520) ay -= 23040;
            if (ay < -11520) ay += 23040;
            for (int k = 0; k < 3; k++)
            begin
                w = '0;
                w.row  = 2'(k);
                w.last = (k == 2);
                if (vert)
                    w.degen = 1'b1;
                else
                begin
                    t = m[k][0] * px[0] + m[k][1] * px[1] + m[k][2] * px[2];
                    t = -fshr(t + (64'sd1 <<< 13), 14);
                    if (t > 64'sd2147483647) t = 64'sd2147483647;
                    if (t < -64'sd2147483648) t = -64'sd2147483648;
                    w.col_a  = 16'(m[k][0]);
                    w.col_b  = 16'(m[k][1]);
                    w.col_c  = 16'(m[k][2]);
                    w.trans  = 32'(t);
                    w.apitch = 14'(ap);
                    w.ayaw   = 15'(ay);
                    w.aroll  = 14'(ar);
                end
                pending_rows.push_back(w);
            end
        endfunction

        function void check_row(logic [127:0] d, logic [2:0] u, logic l);
            row_word_t got, exp_w;
            got.row    = u[1:0];
            got.degen  = u[2];
            got.last   = l;
            got.col_a  = d[15:0];
            got.col_b  = d[31:16];
            got.col_c  = d[47:32];
            got.trans  = d[79:48];
            got.apitch = d[93:80];
            got.ayaw   = d[108:94];
            got.aroll  = d[122:109];
            if (pending_rows.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected row word: %p", got);
                return;
            end
            exp_w = pending_rows.pop_front();
            if (got != exp_w)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("row mismatch\n  exp %p\n  got %p", exp_w, got);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    view_scoreboard sb;
    int  idle_cycles;
    bit  stimulus_done;
    bit  sink_hold;     // long receiver hold-off requested by the source
    bit  timed_out;

    euler_camera_view_matrix dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // scoreboard hookup on both handshakes; watchdog on accept-free cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_pose(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_row(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("tb: failure");
            $finish;
        end
    end

    // drive one pose word, random gap first when gaps is set
    task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic [13:0] pitch,
                             logic [15:0] yaw, bit gaps);
        int gap;
        gap = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15)) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, yaw, pitch, pz, py, px};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic drain_rows();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_rows.size() != 0) @(posedge clk);
    endtask

    function automatic logic [13:0] rand_pitch();
        case ($urandom_range(0, 5))
            0:       return 14'($urandom);            // any pattern
            1:       return $urandom_range(0, 1) ? 14'sd5760 : -14'sd5760;
            2:       return 14'(int'($urandom_range(0, 180)) * 64 - 5760);
            default: return 14'(int'($urandom_range(0, 11520)) - 5760);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    // receiver: random stall per word, one long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                sink_hold = 0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if (stimulus_done || $urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    initial
    begin
        int i;
        sb = new();
        idle_cycles   = 0;
        stimulus_done = 0;
        sink_hold     = 0;
        timed_out     = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: vertical pitch, quadrants, wraps, position extremes
        send_pose(32'sh00010000, 32'sh00020000, 32'sh00030000, 14'sd0, 16'sd0, 0);
        send_pose(32'sh00010000, 32'sh00020000, 32'sh00030000, 14'sd5760, 16'sd0, 0);
        send_pose(32'sh00010000, 32'sh00020000, 32'sh00030000, -14'sd5760, 16'sd1234, 0);
        send_pose(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 14'sd2880, 16'sd5760, 0);
        send_pose(32'sh80000000, 32'sh80000000, 32'sh80000000, -14'sd2880, -16'sd5760, 0);
        send_pose(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 14'sd5759, 16'sd11520, 0);
        send_pose(32'sh80000000, 32'sh7fffffff, 32'sh80000000, -14'sd5759, -16'sd11520, 0);
        send_pose(32'sh0, 32'sh0, 32'sh0, 14'sh1fff, 16'sd23040, 0);      // pitch beyond 90
        send_pose(32'sh0, 32'sh0, 32'sh0, 14'sh2000, -16'sd23040, 0);     // most negative
        send_pose(32'shffffffff, 32'sh1, 32'shffffffff, 14'sd100, 16'sh7fff, 0);
        send_pose(32'sh12345678, 32'shedcba987, 32'sh0, -14'sd100, 16'sh8000, 0);
        send_pose(32'sh55555555, 32'shaaaaaaaa, 32'sh33333333, 14'sd7000, 16'sd17280, 0);
        send_pose(32'shaaaaaaaa, 32'sh55555555, 32'shcccccccc, -14'sd7000, -16'sd17280, 0);
        send_pose(32'sh00100000, 32'sh0, 32'sh00100000, 14'sd0, 16'sd2880, 0);
        drain_rows();

        // fill the block while the receiver holds off; more poses than stages
        sink_hold = 1;
        for (i = 0; i < N_FILL; i++)
            send_pose(rand_pos(), rand_pos(), rand_pos(), rand_pitch(), 16'($urandom), 0);
        drain_rows();

        for (i = 0; i < N_RANDOM; i++)
        begin
            send_pose(rand_pos(), rand_pos(), rand_pos(), rand_pitch(),
                      $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                : 16'(int'($urandom_range(0, 46080)) - 23040),
                      i % 40 >= 20);
            if (i == N_RANDOM / 2)
                drain_rows();
        end
        s_axis_tvalid <= 1'b0;
        stimulus_done = 1;
        @(posedge clk);
        while (sb.pending_rows.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);

        if (sb.n_mismatch == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/evcm_pkg.sv
rtl/evcm_rot_cell.sv
rtl/evcm_vec_cell.sv
rtl/evcm_div_cell.sv
rtl/euler_camera_view_matrix.sv
tb/sv/testbench.sv
